[src/tuner_pll_tune_calibrate_defines.svh]
// Assertion macros for the tuner synthesizer tune controller.
`ifndef TUNER_PLL_TUNE_CALIBRATE_DEFINES_SVH
`define TUNER_PLL_TUNE_CALIBRATE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TPT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tpt assertion failed");

// Check that a condition implies another in the next cycle.
`define TPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tpt assertion failed");

`endif

[src/tpt_pkg.sv]
// Package with types and constants of the tuner synthesizer tune controller.
`timescale 1ns / 1ps
`default_nettype none
package tpt_pkg;

    typedef enum logic [1:0] {
        OUT_NEED_STATUS = 2'd0,
        OUT_TUNED_OK    = 2'd1,
        OUT_RANGE_ERR   = 2'd2,
        OUT_BAND_FAIL   = 2'd3
    } t_outcome;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_TUNE   = 9'b000000010,
        S_CAND   = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_EVAL   = 9'b000100000,
        S_FINISH = 9'b001000000,
        S_STAT   = 9'b010000000,
        S_BB     = 9'b100000000
    } t_state;

    localparam logic [31:0] FREQ_MIN_HZ   = 32'd500000000;
    localparam logic [31:0] FREQ_MAX_HZ   = 32'd2600000000;
    localparam logic [31:0] DIV2_SPLIT_HZ = 32'd1150000000;
    localparam logic [40:0] GOOD_DELTA_HZ = 41'd75000;
    localparam logic [23:0] START_BEST_HZ = 24'd10000000;
    localparam logic [25:0] REF_RESET_HZ  = 26'd4000000;
    localparam logic [14:0] FB_RESET      = 15'd950;

    localparam logic [33:0] BAND_EDGE [7] = '{
        34'd2433000000, 34'd2711000000, 34'd3025000000, 34'd3341000000,
        34'd3727000000, 34'd4143000000, 34'd4493000000
    };

    // r * 500 kHz and (r + 1) * 2 MHz for r = 2 << code
    localparam logic [31:0] RMAX_LIM [7] = '{
        32'd1000000, 32'd2000000, 32'd4000000, 32'd8000000,
        32'd16000000, 32'd32000000, 32'd64000000
    };
    localparam logic [31:0] RMIN_LIM [7] = '{
        32'd6000000, 32'd10000000, 32'd18000000, 32'd34000000,
        32'd66000000, 32'd130000000, 32'd258000000
    };

endpackage
`default_nettype wire

[src/tpt_if.sv]
// Valid/ready channel interfaces of the tuner synthesizer tune controller.
`timescale 1ns / 1ps
`default_nettype none
interface tpt_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] target_freq_hz;
    logic [7:0]  status_byte;
    modport source (output valid, action, target_freq_hz, status_byte, input ready);
    modport sink (input valid, action, target_freq_hz, status_byte, output ready);
endinterface

interface tpt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic        div2_bit;
    logic [7:0]  ref_divider;
    logic [2:0]  ref_divider_code;
    logic [14:0] feedback_divider;
    logic [2:0]  osc_band;
    logic [1:0]  charge_pump;
    logic [31:0] baseband_freq_hz;
    modport source (output valid, outcome, div2_bit, ref_divider, ref_divider_code,
        feedback_divider, osc_band, charge_pump, baseband_freq_hz, input ready);
    modport sink (input valid, outcome, div2_bit, ref_divider, ref_divider_code,
        feedback_divider, osc_band, charge_pump, baseband_freq_hz, output ready);
endinterface

interface tpt_cfg_if;
    logic        valid;
    logic        ready;
    logic [25:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[src/tuner_pll_tune_calibrate.sv]
// Top level of the tuner synthesizer tune and VCO band calibration controller.
// One request is taken at a time. Ready stays low while a request is being
// handled and while its result waits on the output channel. The result is
// loaded by the state that ends the request:
// - the range check state for an out of range tune request;
// - the status state when a status read steps the band or hits a band limit;
// - the baseband state, after the multiply in the status state, for a status
//   read that completes the tune;
// - no result at all for a status read while no calibration is pending.
// An in range tune request passes the range check and then, for each reference
// divider in turn, a candidate check that skips the divider if the reference
// clock limits do so. Else the feedback divider is computed by the 14-step
// restoring divider, one quotient bit a cycle, followed by a multiply state and,
// when the feedback divider is 256 or more, an error compare state. The
// candidate check ends the search when no divider is taken early, and a finish
// state loads the result. Config writes are always ready and must be made only
// while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module tuner_pll_tune_calibrate (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpt_cfg_if.sink   i_cfg,
    tpt_req_if.sink   i_req,
    tpt_res_if.source o_res
);
    import tpt_pkg::*;

    t_state      r_state, n_state;
    logic [25:0] r_ref;
    logic        r_cal;
    logic        r_div2;
    logic [2:0]  r_code;
    logic [14:0] r_fb;
    logic [2:0]  r_band;
    logic [1:0]  r_pump;
    logic        r_out_valid;
    t_outcome    r_outcome;
    logic [31:0] r_bb;
    logic [31:0] r_f;
    logic [7:0]  r_status;
    logic [2:0]  r_rc;
    logic [40:0] r_rem;
    logic [26:0] r_d;
    logic [13:0] r_q;
    logic [3:0]  r_k;
    logic [40:0] r_prod;
    logic [23:0] r_best_delta;
    logic [2:0]  r_best_code;
    logic [13:0] r_best_n;

    logic [33:0] vco;
    logic [2:0]  band_calc;
    logic [40:0] trial;
    logic [40:0] fr;
    logic [40:0] num;
    logic [40:0] delta;
    logic [44:0] delta_x10;
    logic [27:0] best_x9;
    logic [40:0] bb_shift;
    logic [5:0]  adc;
    logic [14:0] mul_a;
    logic [40:0] mul_prod;
    logic        req_fire;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid            = r_out_valid;
    assign o_res.outcome          = r_outcome;
    assign o_res.div2_bit         = r_div2;
    assign o_res.ref_divider      = 8'd2 << r_code;
    assign o_res.ref_divider_code = r_code;
    assign o_res.feedback_divider = r_fb;
    assign o_res.osc_band         = r_band;
    assign o_res.charge_pump      = r_pump;
    assign o_res.baseband_freq_hz = r_bb;

    always_comb begin
        vco = (r_f < DIV2_SPLIT_HZ) ? {r_f, 2'b00} : {1'b0, r_f, 1'b0};
        band_calc = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (vco >= BAND_EDGE[i]) begin
                band_calc = band_calc + 3'd1;
            end
        end
        trial     = {14'd0, r_d} << r_k;
        fr        = {9'd0, r_f} << ({1'b0, r_rc} + 4'd1);
        num       = (r_prod > fr) ? (r_prod - fr) : (fr - r_prod);
        delta     = num >> ({1'b0, r_rc} + 4'd1);
        delta_x10 = {delta, 3'b000} + {3'b000, delta, 1'b0};
        best_x9   = {1'b0, r_best_delta, 3'b000} + {4'd0, r_best_delta};
        bb_shift  = r_prod >> ({1'b0, r_code} + 4'd1);
        adc       = r_status[7:2];
        mul_a     = (r_state == S_STAT) ? r_fb : {1'b0, r_q};
        mul_prod  = 41'(mul_a * r_ref);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = i_req.action ? S_STAT : S_TUNE;
                end
            end
            S_TUNE: begin
                n_state = ((r_f < FREQ_MIN_HZ) || (r_f > FREQ_MAX_HZ)) ? S_IDLE : S_CAND;
            end
            S_CAND: begin
                if ((r_rc == 3'd7) || (RMAX_LIM[r_rc] > {6'd0, r_ref})) begin
                    n_state = S_FINISH;
                end else if ({6'd0, r_ref} < RMIN_LIM[r_rc]) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_k == 4'd0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = (r_q < 14'd256) ? S_CAND : S_EVAL;
            end
            S_EVAL: begin
                n_state = (delta < GOOD_DELTA_HZ) ? S_FINISH : S_CAND;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            S_STAT: begin
                if (r_cal && (adc != 6'd0) && (adc != 6'd7)) begin
                    n_state = S_BB;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BB: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref       <= REF_RESET_HZ;
            r_cal       <= 1'b0;
            r_div2      <= 1'b0;
            r_code      <= 3'd1;
            r_fb        <= FB_RESET;
            r_band      <= 3'd5;
            r_pump      <= 2'd3;
            r_out_valid <= 1'b0;
            r_outcome   <= OUT_NEED_STATUS;
            r_bb        <= 32'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_ref <= i_cfg.data;
            end
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_f      <= i_req.target_freq_hz;
                        r_status <= i_req.status_byte;
                    end
                end
                S_TUNE: begin
                    if ((r_f < FREQ_MIN_HZ) || (r_f > FREQ_MAX_HZ)) begin
                        r_cal       <= 1'b0;
                        r_outcome   <= OUT_RANGE_ERR;
                        r_bb        <= 32'd0;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_div2       <= (r_f >= DIV2_SPLIT_HZ);
                        r_band       <= band_calc;
                        r_cal        <= 1'b1;
                        r_rc         <= 3'd0;
                        r_best_code  <= 3'd0;
                        r_best_n     <= 14'd0;
                        r_best_delta <= START_BEST_HZ;
                    end
                end
                S_CAND: begin
                    if ((r_rc != 3'd7) && (RMAX_LIM[r_rc] <= {6'd0, r_ref})) begin
                        if ({6'd0, r_ref} >= RMIN_LIM[r_rc]) begin
                            r_rc <= r_rc + 3'd1;
                        end else begin
                            r_rem <= ({9'd0, r_f} << ({1'b0, r_rc} + 4'd2))
                                + {15'd0, r_ref};
                            r_d   <= {r_ref, 1'b0};
                            r_k   <= 4'd13;
                            r_q   <= 14'd0;
                        end
                    end
                end
                S_DIV: begin
                    if (r_rem >= trial) begin
                        r_rem      <= r_rem - trial;
                        r_q[r_k]   <= 1'b1;
                    end
                    r_k <= r_k - 4'd1;
                end
                S_MUL: begin
                    if (r_q < 14'd256) begin
                        r_rc <= r_rc + 3'd1;
                    end else begin
                        r_prod <= mul_prod;
                    end
                end
                S_EVAL: begin
                    if (delta < GOOD_DELTA_HZ) begin
                        r_best_code <= r_rc;
                        r_best_n    <= r_q;
                    end else begin
                        if (delta_x10 < {17'd0, best_x9}) begin
                            r_best_code  <= r_rc;
                            r_best_n     <= r_q;
                            r_best_delta <= delta[23:0];
                        end
                        r_rc <= r_rc + 3'd1;
                    end
                end
                S_FINISH: begin
                    r_code      <= r_best_code;
                    r_fb        <= {1'b0, r_best_n};
                    r_outcome   <= OUT_NEED_STATUS;
                    r_bb        <= 32'd0;
                    r_out_valid <= 1'b1;
                end
                S_STAT: begin
                    if (r_cal) begin
                        r_bb <= 32'd0;
                        if (adc == 6'd0) begin
                            r_out_valid <= 1'b1;
                            if (r_band == 3'd0) begin
                                r_cal     <= 1'b0;
                                r_outcome <= OUT_BAND_FAIL;
                            end else begin
                                r_band    <= r_band - 3'd1;
                                r_outcome <= OUT_NEED_STATUS;
                            end
                        end else if (adc == 6'd7) begin
                            r_out_valid <= 1'b1;
                            if (r_band == 3'd7) begin
                                r_cal     <= 1'b0;
                                r_outcome <= OUT_BAND_FAIL;
                            end else begin
                                r_band    <= r_band + 3'd1;
                                r_outcome <= OUT_NEED_STATUS;
                            end
                        end else begin
                            if (adc <= 6'd2) begin
                                r_pump <= 2'd1;
                            end else if (adc <= 6'd4) begin
                                r_pump <= 2'd2;
                            end else begin
                                r_pump <= 2'd3;
                            end
                            r_cal  <= 1'b0;
                            r_prod <= mul_prod;
                        end
                    end
                end
                S_BB: begin
                    r_bb        <= (bb_shift[40:32] != 9'd0) ? 32'hFFFF_FFFF : bb_shift[31:0];
                    r_outcome   <= OUT_TUNED_OK;
                    r_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[src/tpt_checker.sv]
// Port-level checker of the tuner synthesizer tune controller, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "tuner_pll_tune_calibrate_defines.svh"
module tpt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic [1:0]  i_outcome,
    input wire logic [7:0]  i_ref_divider,
    input wire logic [2:0]  i_ref_divider_code,
    input wire logic [31:0] i_baseband_freq_hz
);
    import tpt_pkg::*;

    `TPT_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_outcome) && $stable(i_baseband_freq_hz))
    `TPT_ASSERT_NOW(a_no_req_while_res, i_clk, i_rst_n, i_res_valid, !i_req_ready)
    `TPT_ASSERT_NOW(a_bb_zero, i_clk, i_rst_n, i_res_valid && (i_outcome != OUT_TUNED_OK), i_baseband_freq_hz == 32'd0)
    `TPT_ASSERT_NOW(a_div_code, i_clk, i_rst_n, i_res_valid, i_ref_divider == (8'd2 << i_ref_divider_code))

endmodule

bind tuner_pll_tune_calibrate tpt_checker u_tpt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_outcome          (o_res.outcome),
    .i_ref_divider      (o_res.ref_divider),
    .i_ref_divider_code (o_res.ref_divider_code),
    .i_baseband_freq_hz (o_res.baseband_freq_hz)
);
`default_nettype wire

[dv/tuner_pll_tune_calibrate_checker.sv]
// Checker that predicts and compares tune controller results on its channels.
`timescale 1ns / 1ps
module tuner_pll_tune_calibrate_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpt_cfg_if          cfg,
    tpt_req_if          req,
    tpt_res_if          res,
    output int          o_pending,
    output int          o_errors
);
    import tpt_pkg::*;

    typedef struct packed {
        t_outcome    outcome;
        logic        div2_bit;
        logic [7:0]  ref_divider;
        logic [2:0]  ref_divider_code;
        logic [14:0] feedback_divider;
        logic [2:0]  osc_band;
        logic [1:0]  charge_pump;
        logic [31:0] baseband_freq_hz;
    } t_tune_result;

    t_tune_result tune_expected[$];

    logic [25:0] ref_hz;
    logic        busy_cal;
    logic        div2_q;
    logic [7:0]  rdiv_q;
    logic [14:0] fbdiv_q;
    logic [2:0]  band_q;
    logic [1:0]  pump_q;

    assign o_pending = tune_expected.size();

    function automatic logic [2:0] rdiv_code(logic [7:0] r);
        logic [2:0] c;
        c = 3'd0;
        while (r > 8'd2 && c < 3'd7) begin
            r = r >> 1;
            c++;
        end
        return c;
    endfunction

    function automatic t_tune_result snapshot(t_outcome oc, logic [31:0] bb);
        t_tune_result t;
        t.outcome          = oc;
        t.div2_bit         = div2_q;
        t.ref_divider      = rdiv_q;
        t.ref_divider_code = rdiv_code(rdiv_q);
        t.feedback_divider = fbdiv_q;
        t.osc_band         = band_q;
        t.charge_pump      = pump_q;
        t.baseband_freq_hz = bb;
        return t;
    endfunction

    task automatic queue_expect(t_tune_result t);
        tune_expected = {tune_expected, t};
    endtask

    task automatic start_tune(logic [31:0] f_in);
        logic [63:0] f, rf, vco, rmin, rmax, r, best_r, best_n, best_d, n, prod, fr, num, d;
        logic [2:0]  b;
        f = f_in;
        rf = ref_hz;
        rmin = rf / 2000000;
        rmax = rf / 500000;
        best_r = 2;
        best_n = 0;
        best_d = 10000000;
        if (rmin < 2) rmin = 2;
        if (rmax > 128) rmax = 128;
        if (f < DIV2_SPLIT_HZ) begin
            div2_q = 1'b0;
            vco = 4 * f;
        end else begin
            div2_q = 1'b1;
            vco = 2 * f;
        end
        for (r = 2; r <= rmax; r = r * 2) begin
            n = (2 * f * r + rf) / (2 * rf);
            if (r >= rmin && n >= 256) begin
                prod = n * rf;
                fr = f * r;
                num = prod > fr ? prod - fr : fr - prod;
                d = num / r;
                if (d < 75000) begin
                    best_r = r;
                    best_n = n;
                    break;
                end
                if (10 * d < 9 * best_d) begin
                    best_r = r;
                    best_n = n;
                    best_d = d;
                end
            end
        end
        rdiv_q = best_r[7:0];
        fbdiv_q = best_n[14:0];
        b = 3'd0;
        while (b < 3'd7 && vco >= BAND_EDGE[b]) b++;
        band_q = b;
        busy_cal = 1'b1;
    endtask

    task automatic apply_request(logic act, logic [31:0] f, logic [7:0] sb);
        logic [5:0]  adc;
        logic [63:0] bb;
        if (act == 1'b0) begin
            if (f < FREQ_MIN_HZ || f > FREQ_MAX_HZ) begin
                busy_cal = 1'b0;
                queue_expect(snapshot(OUT_RANGE_ERR, 32'd0));
            end else begin
                start_tune(f);
                queue_expect(snapshot(OUT_NEED_STATUS, 32'd0));
            end
        end else if (busy_cal) begin
            adc = sb[7:2];
            if (adc == 6'd0 || adc == 6'd7) begin
                if ((adc == 6'd0 && band_q == 3'd0) || (adc == 6'd7 && band_q == 3'd7)) begin
                    busy_cal = 1'b0;
                    queue_expect(snapshot(OUT_BAND_FAIL, 32'd0));
                end else begin
                    band_q = (adc == 6'd0) ? band_q - 3'd1 : band_q + 3'd1;
                    queue_expect(snapshot(OUT_NEED_STATUS, 32'd0));
                end
            end else begin
                pump_q = adc <= 6'd2 ? 2'd1 : adc <= 6'd4 ? 2'd2 : 2'd3;
                busy_cal = 1'b0;
                bb = rdiv_q != 8'd0 ? (64'(fbdiv_q) * 64'(ref_hz)) / 64'(rdiv_q) : 64'd0;
                if (bb > 64'hFFFFFFFF) bb = 64'hFFFFFFFF;
                queue_expect(snapshot(OUT_TUNED_OK, bb[31:0]));
            end
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("tuner check: %s got %0d want %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_tune_result w;
        if (!i_rst_n) begin
            ref_hz = REF_RESET_HZ;
            busy_cal = 1'b0;
            div2_q = 1'b0;
            rdiv_q = 8'd4;
            fbdiv_q = FB_RESET;
            band_q = 3'd5;
            pump_q = 2'd3;
            o_errors = o_errors;
        end else begin
            if (res.valid && res.ready) begin
                if (tune_expected.size() == 0) begin
                    report("unexpected result", 32'(res.outcome), 32'd0);
                end else begin
                    w = tune_expected.pop_front();
                    if (res.outcome != w.outcome) report("outcome", res.outcome, w.outcome);
                    if (res.div2_bit != w.div2_bit) report("div2_bit", res.div2_bit, w.div2_bit);
                    if (res.ref_divider != w.ref_divider)
                        report("ref_divider", res.ref_divider, w.ref_divider);
                    if (res.ref_divider_code != w.ref_divider_code)
                        report("ref_divider_code", res.ref_divider_code, w.ref_divider_code);
                    if (res.feedback_divider != w.feedback_divider)
                        report("feedback_divider", res.feedback_divider, w.feedback_divider);
                    if (res.osc_band != w.osc_band) report("osc_band", res.osc_band, w.osc_band);
                    if (res.charge_pump != w.charge_pump)
                        report("charge_pump", res.charge_pump, w.charge_pump);
                    if (res.baseband_freq_hz != w.baseband_freq_hz)
                        report("baseband_freq_hz", res.baseband_freq_hz, w.baseband_freq_hz);
                end
            end
            if (req.valid && req.ready)
                apply_request(req.action, req.target_freq_hz, req.status_byte);
            if (cfg.valid && cfg.ready) ref_hz = cfg.data;
        end
    end

    initial o_errors = 0;

endmodule

[dv/tb_top.sv]
// Testbench top for the tuner synthesizer tune and calibration controller.
`timescale 1ns / 1ps
module tb_top;
    import tpt_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   pending, errors;
    int   send_idle_pct = 0, stall_pct = 0;
    int   quiet = 0;

    tpt_cfg_if cfg_ch();
    tpt_req_if req_ch();
    tpt_res_if res_ch();

    tuner_pll_tune_calibrate uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg_ch), .i_req(req_ch), .o_res(res_ch)
    );

    tuner_pll_tune_calibrate_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg(cfg_ch), .req(req_ch), .res(res_ch),
        .o_pending(pending), .o_errors(errors)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= 5000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_request(logic act, logic [31:0] f, logic [7:0] sb);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 0;
            @(negedge i_clk);
        end
        req_ch.valid = 1;
        req_ch.action = act;
        req_ch.target_freq_hz = f;
        req_ch.status_byte = sb;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic send_tune(logic [31:0] f);
        send_request(0, f, 8'($urandom));
    endtask

    task automatic send_status(logic [5:0] adc);
        send_request(1, 32'($urandom), {adc, 2'($urandom)});
    endtask

    task automatic write_ref(logic [25:0] v);
        @(negedge i_clk);
        req_ch.valid = 0;
        wait (pending == 0);
        repeat (200) @(negedge i_clk);
        cfg_ch.valid = 1;
        cfg_ch.data = v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 0;
    endtask

    function automatic logic [5:0] pick_adc();
        int k;
        k = $urandom_range(9);
        if (k < 3) return 6'd0;
        if (k < 6) return 6'd7;
        return 6'($urandom);
    endfunction

    task automatic random_phase(int items);
        int cnt, k;
        cnt = 0;
        while (cnt < items) begin
            if ($urandom_range(99) < 85) begin
                send_tune($urandom_range(32'd2600000000, 32'd500000000));
                cnt++;
                k = $urandom_range(6, 1);
                repeat (k) begin
                    send_status(pick_adc());
                    cnt++;
                end
            end else if ($urandom_range(1)) begin
                send_tune($urandom);
                cnt++;
            end else begin
                send_status(6'($urandom));
            end
        end
    endtask

    initial begin
        logic [25:0] refs [6];
        int p;
        req_ch.valid = 0;
        req_ch.action = 0;
        req_ch.target_freq_hz = 0;
        req_ch.status_byte = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = 0;
        res_ch.ready = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_status(6'd3);
        send_tune(0);
        send_tune(32'd499999999);
        send_tune(32'd2600000001);
        send_tune(32'hFFFFFFFF);
        send_tune(32'd500000000);
        repeat (6) send_status(6'd0);
        send_tune(32'd2600000000);
        repeat (3) send_status(6'd7);
        send_tune(32'd1149999999);
        send_status(6'd1);
        send_tune(32'd1150000000);
        send_status(6'd2);
        send_tune(32'd915000000);
        send_tune(32'd1575420000);
        send_status(6'd4);
        send_tune(32'd2000000000);
        send_status(6'd63);
        send_status(6'd5);

        refs = '{26'd1000000, 26'd64000000, 26'd4000000, 26'd27000000, 26'd10000000, 26'd0};
        for (p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            write_ref(p < 6 ? refs[p] : 26'($urandom_range(64000000, 1000000)));
            random_phase(72);
        end

        @(negedge i_clk);
        req_ch.valid = 0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
